// ----- rtl/rwa_pkg.sv -----
// ----------------------------------------------------------------------------
// rwa_pkg : shared definitions for the rolling window average
// Field widths, default window depth, queue depth and state encodings.
// ----------------------------------------------------------------------------
package rwa_pkg;

    // Fixed field widths
    localparam int PRICE_W = 32;
    localparam int CFG_W   = 9;
    localparam int AVG_W   = 48;
    localparam int FRAC_W  = 16;

    // Default ring depth and window length after reset
    localparam int MAX_WINDOW_DEF = 256;
    localparam int WINDOW_RESET   = 256;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        F_IDLE,
        F_UPDATE
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_DONE
    } t_back_state;

endpackage

// ----- rtl/rwa_front.sv -----
// ----------------------------------------------------------------------------
// rwa_front : sample intake and running sum
// Takes each price, drops the oldest sample once the window is full, keeps
// the ring, the running sum and the fill count, and queues {sum, count}.
// ----------------------------------------------------------------------------
module rwa_front #(
    parameter int MAX_WINDOW = rwa_pkg::MAX_WINDOW_DEF,
    parameter int PTR_W      = $clog2(MAX_WINDOW),
    parameter int CNT_W      = $clog2(MAX_WINDOW + 1),
    parameter int SUM_W      = rwa_pkg::PRICE_W + PTR_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rwa_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rwa_pkg::PRICE_W-1:0] i_price,
    output logic                       o_push,
    output logic [SUM_W-1:0]           o_push_sum,
    output logic [CNT_W-1:0]           o_push_cnt,
    input  logic                       i_queue_full
);

    localparam int CMP_W = (CNT_W > rwa_pkg::CFG_W) ? CNT_W : rwa_pkg::CFG_W;

    rwa_pkg::t_front_state r_state, n_state;

    logic [rwa_pkg::CFG_W-1:0]   r_window;
    logic [PTR_W-1:0]            r_wptr;
    logic [CNT_W-1:0]            r_fill;
    logic [SUM_W-1:0]            r_sum;

    logic [rwa_pkg::PRICE_W-1:0] r_ring [MAX_WINDOW];
    logic [rwa_pkg::PRICE_W-1:0] r_rd_data;
    logic [rwa_pkg::PRICE_W-1:0] r_price;
    logic                        r_full;

    logic             accept;
    logic [CMP_W-1:0] win_ext;
    logic [CNT_W-1:0] win_eff;
    logic [CNT_W:0]   oldest_wide;
    logic [PTR_W-1:0] oldest;
    logic             full;
    logic [SUM_W-1:0] drop;
    logic [SUM_W-1:0] new_sum;
    logic [CNT_W-1:0] new_fill;
    logic [PTR_W-1:0] next_wptr;

    // Window clamp: zero acts as one, above the ring depth saturates
    always_comb begin
        win_ext = CMP_W'(r_window);
        if (win_ext == '0) begin
            win_eff = CNT_W'(1);
        end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
            win_eff = CNT_W'(MAX_WINDOW);
        end else begin
            win_eff = CNT_W'(win_ext);
        end
    end

    // Oldest slot in the window, modulo ring depth
    always_comb begin
        if ({1'b0, CNT_W'(r_wptr)} >= {1'b0, win_eff}) begin
            oldest_wide = {1'b0, CNT_W'(r_wptr)} - {1'b0, win_eff};
        end else begin
            oldest_wide = {1'b0, CNT_W'(r_wptr)} + (CNT_W + 1)'(MAX_WINDOW)
                          - {1'b0, win_eff};
        end
        oldest = oldest_wide[PTR_W-1:0];
        full   = (r_fill >= win_eff);
    end

    // Sum update and pointer wrap
    always_comb begin
        drop      = r_full ? SUM_W'(r_rd_data) : '0;
        new_sum   = r_sum - drop + SUM_W'(r_price);
        new_fill  = r_full ? r_fill : r_fill + CNT_W'(1);
        next_wptr = (r_wptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wptr + PTR_W'(1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rwa_pkg::F_IDLE: begin
                if (i_valid) n_state = rwa_pkg::F_UPDATE;
            end
            rwa_pkg::F_UPDATE: begin
                if (!i_queue_full) n_state = rwa_pkg::F_IDLE;
            end
            default: n_state = rwa_pkg::F_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            rwa_pkg::F_IDLE:   o_ready = 1'b1;
            rwa_pkg::F_UPDATE: o_push  = !i_queue_full;
            default: begin
                o_ready = 1'b0;
                o_push  = 1'b0;
            end
        endcase
    end

    assign accept     = i_valid && o_ready;
    assign o_push_sum = new_sum;
    assign o_push_cnt = new_fill;

    // Control state; a window write clears the history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rwa_pkg::F_IDLE;
            r_window <= rwa_pkg::CFG_W'(rwa_pkg::WINDOW_RESET);
            r_wptr   <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
                r_wptr   <= '0;
                r_fill   <= '0;
                r_sum    <= '0;
            end else if (o_push) begin
                r_wptr <= next_wptr;
                r_fill <= new_fill;
                r_sum  <= new_sum;
            end
        end
    end

    // Captured sample and full flag
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_price <= i_price;
            r_full  <= full;
        end
    end

    // Sample ring: read oldest on transfer, write new sample on push
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_ring[oldest];
        end
        if (o_push) begin
            r_ring[r_wptr] <= r_price;
        end
    end

endmodule

// ----- rtl/rwa_queue.sv -----
// ----------------------------------------------------------------------------
// rwa_queue : short queue between front and back
// Holds {sum, count} jobs so the front and the divider stall independently.
// ----------------------------------------------------------------------------
module rwa_queue #(
    parameter int DATA_W = 49
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = rwa_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/rwa_back.sv -----
// ----------------------------------------------------------------------------
// rwa_back : serial divider and output register
// Computes (sum * 2^16) / count one quotient bit per cycle, restoring form.
// ----------------------------------------------------------------------------
module rwa_back #(
    parameter int CNT_W = 9,
    parameter int SUM_W = 40
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  logic [SUM_W-1:0]          i_sum,
    input  logic [CNT_W-1:0]          i_cnt,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [rwa_pkg::AVG_W-1:0] o_average
);

    localparam int DIV_W  = SUM_W + rwa_pkg::FRAC_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    rwa_pkg::t_back_state r_state, n_state;

    logic [DIV_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [rwa_pkg::AVG_W-1:0] r_average;

    logic             last_step;
    logic             out_free;
    logic             load;
    logic             step;
    logic             emit;
    logic [CNT_W:0]   trial;
    logic             ge;

    assign last_step = (r_step == STEP_W'(DIV_W - 1));
    assign out_free  = !r_out_valid || i_ready;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        ge    = (trial >= {1'b0, r_div});
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rwa_pkg::B_IDLE: begin
                if (!i_empty) n_state = rwa_pkg::B_RUN;
            end
            rwa_pkg::B_RUN: begin
                if (last_step) n_state = rwa_pkg::B_DONE;
            end
            rwa_pkg::B_DONE: begin
                if (out_free) n_state = rwa_pkg::B_IDLE;
            end
            default: n_state = rwa_pkg::B_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        load = 1'b0;
        step = 1'b0;
        emit = 1'b0;
        case (r_state)
            rwa_pkg::B_IDLE: load = !i_empty;
            rwa_pkg::B_RUN:  step = 1'b1;
            rwa_pkg::B_DONE: emit = out_free;
            default: begin
                load = 1'b0;
                step = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    assign o_pop     = load;
    assign o_valid   = r_out_valid;
    assign o_average = r_average;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rwa_pkg::B_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_step <= '0;
            end else if (step) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Divider datapath and output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_quo <= {i_sum, rwa_pkg::FRAC_W'(0)};
            r_rem <= '0;
            r_div <= i_cnt;
        end else if (step) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? CNT_W'(trial - {1'b0, r_div}) : CNT_W'(trial);
        end
        if (emit) begin
            r_average <= r_quo[rwa_pkg::AVG_W-1:0];
        end
    end

endmodule

// ----- rtl/rolling_window_average_top.sv -----
// ----------------------------------------------------------------------------
// rolling_window_average_top : simple moving average of price samples
// Front end keeps the sample ring and running sum, back end divides.
// ----------------------------------------------------------------------------
// Each accepted price yields one average: the mean of the latest samples, up
// to the window length, as a truncated quotient with 16 fractional bits. Until
// the window fills, the mean is over all samples since the last clear. A
// write to the window register clears the history; zero acts as one and
// values above MAX_WINDOW saturate. The front end pushes each accepted price
// as a job into a two-deep queue and takes no new one until that push; the
// sustained rate is set by the bit-serial divider, whose quotient is SUM_W +
// 16 bits wide, where SUM_W is 32 + clog2(MAX_WINDOW). The result sits in an
// output register, so the divider goes on with the next job while it waits.
module rolling_window_average_top #(
    parameter int MAX_WINDOW = rwa_pkg::MAX_WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rwa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rwa_pkg::PRICE_W-1:0] i_price,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rwa_pkg::AVG_W-1:0]   o_average
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = rwa_pkg::PRICE_W + PTR_W;
    localparam int JOB_W = SUM_W + CNT_W;

    logic             push, pop, q_full, q_empty;
    logic [SUM_W-1:0] push_sum;
    logic [CNT_W-1:0] push_cnt;
    logic [JOB_W-1:0] q_data;

    // Intake, ring and running sum
    rwa_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_price      (i_price),
        .o_push       (push),
        .o_push_sum   (push_sum),
        .o_push_cnt   (push_cnt),
        .i_queue_full (q_full)
    );

    // Job queue
    rwa_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_sum, push_cnt}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // Divider and output register
    rwa_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_sum     (q_data[JOB_W-1:CNT_W]),
        .i_cnt     (q_data[CNT_W-1:0]),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_average (o_average)
    );

endmodule

// ----- tb/rwa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_checker : result checker for the rolling window average
// Watches the window register port and both channels, keeps its own copy of
// the sample history and compares every returned average in transfer order.
// ----------------------------------------------------------------------------
module rwa_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rwa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [rwa_pkg::PRICE_W-1:0] i_price,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [rwa_pkg::AVG_W-1:0]   i_average,
    output int                          o_mismatches,
    output int                          o_pending
);

    localparam int PTR_W = $clog2(rwa_pkg::MAX_WINDOW_DEF);
    localparam int SUM_W = rwa_pkg::PRICE_W + PTR_W;
    localparam int DIV_W = SUM_W + rwa_pkg::FRAC_W;

    // Shadow of the block's history
    logic [rwa_pkg::PRICE_W-1:0] price_hist [rwa_pkg::MAX_WINDOW_DEF];
    logic [PTR_W-1:0]            hist_wr_ptr;
    logic [rwa_pkg::CFG_W-1:0]   hist_fill;
    logic [SUM_W-1:0]            hist_sum;
    logic [rwa_pkg::CFG_W-1:0]   window_reg;

    // Averages still owed by the block, oldest first
    logic [rwa_pkg::AVG_W-1:0]   owed_averages [$];
    logic [rwa_pkg::AVG_W-1:0]   owed;
    int                          n_results;

    // Zero acts as one, anything above the ring depth saturates
    function automatic logic [rwa_pkg::CFG_W-1:0] active_window();
        if (window_reg == '0) begin
            return rwa_pkg::CFG_W'(1);
        end
        if (window_reg > rwa_pkg::MAX_WINDOW_DEF) begin
            return rwa_pkg::CFG_W'(rwa_pkg::MAX_WINDOW_DEF);
        end
        return window_reg;
    endfunction

    // Take one sample into the history and return the new window mean
    function automatic logic [rwa_pkg::AVG_W-1:0] take_price(
        input logic [rwa_pkg::PRICE_W-1:0] price
    );
        logic [rwa_pkg::CFG_W-1:0] span;
        logic [PTR_W-1:0]          oldest;
        logic [DIV_W-1:0]          scaled;
        span = active_window();
        if (hist_fill >= span) begin
            // window full: oldest sample leaves the sum
            oldest   = PTR_W'(hist_wr_ptr - span);
            hist_sum = hist_sum - SUM_W'(price_hist[oldest]);
        end else begin
            hist_fill = hist_fill + rwa_pkg::CFG_W'(1);
        end
        price_hist[hist_wr_ptr] = price;
        hist_sum    = hist_sum + SUM_W'(price);
        hist_wr_ptr = hist_wr_ptr + PTR_W'(1);
        scaled      = {hist_sum, {rwa_pkg::FRAC_W{1'b0}}} / DIV_W'(hist_fill);
        return scaled[rwa_pkg::AVG_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR: %s", $time, what);
        o_mismatches++;
    endtask

    // Sample everything at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hist_wr_ptr = '0;
            hist_fill   = '0;
            hist_sum    = '0;
            window_reg  = rwa_pkg::CFG_W'(rwa_pkg::WINDOW_RESET);
            n_results   = 0;
            owed_averages.delete();
            o_pending <= 0;
        end else begin
            // window write clears the history
            if (i_cfg_we) begin
                window_reg  = i_cfg_wdata;
                hist_wr_ptr = '0;
                hist_fill   = '0;
                hist_sum    = '0;
            end
            // result transfer against the oldest owed average
            if (i_out_valid && i_out_ready) begin
                if (owed_averages.size() == 0) begin
                    report_mismatch($sformatf("average %h with nothing outstanding",
                                              i_average));
                end else begin
                    owed = owed_averages.pop_front();
                    if (i_average !== owed) begin
                        report_mismatch($sformatf("result %0d average: want %h, got %h",
                                                  n_results, owed, i_average));
                    end
                end
                n_results++;
            end
            // price transfer
            if (i_in_valid && i_in_ready) begin
                owed_averages.insert(owed_averages.size(), take_price(i_price));
            end
            o_pending <= owed_averages.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : testbench for the rolling window average
// Drives price samples and window writes with random gaps and back-pressure;
// the checker alongside predicts and compares each average.
// ----------------------------------------------------------------------------
module tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int SETTLE       = 4;
    localparam int NUM_PHASES   = 12;

    typedef enum logic [1:0] {
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_NONE
    } t_idle_mode;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [rwa_pkg::CFG_W-1:0]   i_cfg_wdata = '0;
    logic                        i_valid     = 1'b0;
    logic                        o_ready;
    logic [rwa_pkg::PRICE_W-1:0] i_price     = '0;
    logic                        o_valid;
    logic                        i_ready     = 1'b0;
    logic [rwa_pkg::AVG_W-1:0]   o_average;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;
    int mismatches;
    int pending;

    logic [rwa_pkg::PRICE_W-1:0] edge_prices [8] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                     32'hFFFF_FFFF, 32'h0000_0001,
                                                     32'hAAAA_AAAA, 32'h5555_5555,
                                                     32'h8000_0000, 32'h7FFF_FFFF};
    logic [rwa_pkg::PRICE_W-1:0] short_prices [3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                      32'h0000_0000};
    // one, zero (acts as one), two, all ones and just above the ring depth
    logic [rwa_pkg::CFG_W-1:0]   edge_windows [5] = '{9'd1, 9'd0, 9'd2, 9'd511, 9'd257};

    rolling_window_average_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_price     (i_price),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_average   (o_average)
    );

    rwa_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_price      (i_price),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_average    (o_average),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: too long without any transfer or write
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct = 38;
                recv_idle_pct = 52;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 52;
                recv_idle_pct = 38;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Valid is only dropped here when a gap is taken, so it never falls and rises
    // in the same step
    task automatic send_price(input logic [rwa_pkg::PRICE_W-1:0] price);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_price <= price;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Step past the last transfer, then wait until every average is back
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Window writes only with the block idle
    task automatic set_window(input logic [rwa_pkg::CFG_W-1:0] window);
        i_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= window;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly full-range values, with a share of extremes and near-extremes
    function automatic logic [rwa_pkg::PRICE_W-1:0] pick_price();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return rwa_pkg::PRICE_W'($urandom_range(255));
            3:       return ~rwa_pkg::PRICE_W'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [rwa_pkg::CFG_W-1:0] window;
        int                        n_items;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset window of 256, then the window edge cases
        set_idling(IDLE_SENDER);
        foreach (edge_prices[k]) send_price(edge_prices[k]);
        foreach (edge_windows[w]) begin
            set_window(edge_windows[w]);
            foreach (short_prices[k]) send_price(short_prices[k]);
        end

        // Random phases over a spread of windows, large ones run long enough
        // for the ring pointer to wrap
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_idling(ph < 4 ? IDLE_SENDER : (ph < 8 ? IDLE_RECEIVER : IDLE_NONE));
            case (ph % 6)
                0:       window = rwa_pkg::CFG_W'($urandom_range(1, 8));
                1:       window = rwa_pkg::CFG_W'(rwa_pkg::MAX_WINDOW_DEF);
                2:       window = rwa_pkg::CFG_W'($urandom_range(9, 64));
                3:       window = (ph < 6) ? '1 : rwa_pkg::CFG_W'(rwa_pkg::MAX_WINDOW_DEF + 1);
                4:       window = '0;
                default: window = rwa_pkg::CFG_W'($urandom_range(65, 300));
            endcase
            n_items = (window > 128) ? 270 : 80;
            set_window(window);
            repeat (n_items) send_price(pick_price());
        end

        // Drain and verdict
        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
